// ----- design/dtp_pkg.sv -----
// ----------------------------------------------------------------------------
// dtp_pkg: shared types and constants for the duration text parser
// Character codes, unit scales, status codes and the classified item that
// travels from the front end to the back end through the queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dtp_pkg;

  // Status codes reported with every result
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BOUNDS  = 2'd1,
    ST_INVALID = 2'd2,
    ST_NOUNIT  = 2'd3
  } status_t;

  // Character classes decided by the front end
  typedef enum logic [2:0] {
    CLS_DIGIT = 3'd0,
    CLS_MINUS = 3'd1,
    CLS_UNIT  = 3'd2,
    CLS_OTHER = 3'd3,
    CLS_END   = 3'd4
  } char_class_t;

  // Unit letters
  typedef enum logic [1:0] {
    UNIT_MIN  = 2'd0,
    UNIT_HOUR = 2'd1,
    UNIT_DAY  = 2'd2,
    UNIT_WEEK = 2'd3
  } unit_t;

  // ASCII codes
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_W     = 8'h77;

  // Minutes per unit
  localparam int SCALE_H = 60;
  localparam int SCALE_D = 24 * SCALE_H;
  localparam int SCALE_W = 7 * SCALE_D;

  // Bits that the largest scale adds to a value
  localparam int SCALE_BITS = $clog2(SCALE_W + 1);

  // Queue between front and back end
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    char_class_t cls;
    logic [3:0]  digit;
    unit_t       unit;
  } item_t;

endpackage

`default_nettype wire

// ----- design/dtp_if.sv -----
// ----------------------------------------------------------------------------
// dtp_in_if / dtp_out_if: valid/ready channels of the duration text parser
// The input channel carries one character or an end marker per transfer;
// the output channel carries one status and running total per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface dtp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_text;

  modport source (output valid, output char_byte, output end_of_text, input ready);
  modport sink   (input valid, input char_byte, input end_of_text, output ready);
endinterface

interface dtp_out_if #(
  parameter int TOTAL_WIDTH = 64
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic                          done_res;
  logic signed [TOTAL_WIDTH-1:0] total_minutes;

  modport source (output valid, output status, output done_res, output total_minutes,
                  input ready);
  modport sink   (input valid, input status, input done_res, input total_minutes,
                  output ready);
endinterface

`default_nettype wire

// ----- design/duration_text_parser.sv -----
// ----------------------------------------------------------------------------
// duration_text_parser: streaming parser for duration strings like "1w-2d30m"
// Classifier front end, two-entry queue, evaluation back end.
// ----------------------------------------------------------------------------
// One character (or an end-of-text marker) is taken per transfer on chars,
// and every transfer gives exactly one result on results: the sticky status
// and the running total in minutes, or, for an end marker, the final status
// (missing unit included) with done_res set, after which the state clears
// for the next string. Sustained rate is one item per clock in both
// directions while results are taken as they come. A character passes
// through a queue entry and then the back end loads the result register.
// While results are held off, the two queue entries and the result register
// fill up and chars then stalls until a result is taken. The rate is set
// by the back end's state update, which keeps the pending value together
// with its hour, day and week multiples so that a unit letter is one signed
// add and range check on the total.
`default_nettype none

module duration_text_parser #(
  parameter int TOTAL_WIDTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  dtp_in_if.sink     chars,
  dtp_out_if.source  results
);
  import dtp_pkg::*;

  logic  f_valid;
  logic  f_ready;
  item_t f_item;
  logic  b_valid;
  logic  b_ready;
  item_t b_item;

  dtp_front u_front (
    .chars   (chars),
    .q_valid (f_valid),
    .q_item  (f_item),
    .q_ready (f_ready)
  );

  dtp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_item  (f_item),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_item  (b_item)
  );

  dtp_back #(
    .TOTAL_WIDTH (TOTAL_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (b_valid),
    .q_ready (b_ready),
    .q_item  (b_item),
    .results (results)
  );

endmodule

`default_nettype wire

// ----- design/dtp_front.sv -----
// ----------------------------------------------------------------------------
// dtp_front: character classifier
// Sorts each incoming character into digit, minus, unit letter, other or
// end of text and hands the classified item to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dtp_front (
  dtp_in_if.sink          chars,
  output logic            q_valid,
  output dtp_pkg::item_t  q_item,
  input  logic            q_ready
);
  import dtp_pkg::*;

  // Handshake passes straight to the queue write port
  assign q_valid     = chars.valid;
  assign chars.ready = q_ready;

  // Classification
  always_comb begin
    q_item.digit = chars.char_byte[3:0];
    q_item.unit  = UNIT_MIN;
    q_item.cls   = CLS_OTHER;
    if (chars.end_of_text) begin
      q_item.cls = CLS_END;
    end else begin
      case (chars.char_byte) inside
        [CH_0:CH_9]: q_item.cls = CLS_DIGIT;
        CH_MINUS:    q_item.cls = CLS_MINUS;
        CH_M: begin
          q_item.cls  = CLS_UNIT;
          q_item.unit = UNIT_MIN;
        end
        CH_H: begin
          q_item.cls  = CLS_UNIT;
          q_item.unit = UNIT_HOUR;
        end
        CH_D: begin
          q_item.cls  = CLS_UNIT;
          q_item.unit = UNIT_DAY;
        end
        CH_W: begin
          q_item.cls  = CLS_UNIT;
          q_item.unit = UNIT_WEEK;
        end
        default:     q_item.cls = CLS_OTHER;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/dtp_queue.sv -----
// ----------------------------------------------------------------------------
// dtp_queue: short FIFO of classified items
// Decouples the classifier from the evaluation stage so that either side
// can stall; the other is held up only once the queue fills or runs dry.
// ----------------------------------------------------------------------------
`default_nettype none

module dtp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  dtp_pkg::item_t  wr_item,
  output logic            rd_valid,
  input  logic            rd_ready,
  output dtp_pkg::item_t  rd_item
);
  import dtp_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  item_t         entries [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  logic wr_fire;
  logic rd_fire;

  assign wr_ready = (count != CW'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_item  = entries[rd_ptr];
  assign wr_fire  = wr_valid && wr_ready;
  assign rd_fire  = rd_valid && rd_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (wr_fire) begin
      entries[wr_ptr] <= wr_item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_fire) begin
        wr_ptr <= (wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_fire) begin
        rd_ptr <= (rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_fire && !rd_fire) begin
        count <= count + 1'b1;
      end else if (rd_fire && !wr_fire) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/dtp_back.sv -----
// ----------------------------------------------------------------------------
// dtp_back: evaluation stage
// Keeps the parse state, applies one classified item per cycle whenever the
// result register is free, and loads it. The pending value is kept alongside
// its hour, day and week multiples so a unit letter costs one wide add and compare.
// ----------------------------------------------------------------------------
`default_nettype none

module dtp_back #(
  parameter int TOTAL_WIDTH = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  output logic            q_ready,
  input  dtp_pkg::item_t  q_item,
  dtp_out_if.source       results
);
  import dtp_pkg::*;

  localparam int W  = TOTAL_WIDTH;
  localparam int PW = W - 1 + SCALE_BITS;  // scaled pending width
  localparam int DW = W + 3;               // pending times ten plus digit

  // Parse state
  logic [W-1:0]  total;
  logic [W-2:0]  pend;
  logic [PW-1:0] pend_h;
  logic [PW-1:0] pend_d;
  logic [PW-1:0] pend_w;
  logic          minus_seen;
  logic          needs_unit;
  status_t       err;

  logic [W-1:0]  total_next;
  logic [W-2:0]  pend_next;
  logic [PW-1:0] pend_h_next;
  logic [PW-1:0] pend_d_next;
  logic [PW-1:0] pend_w_next;
  logic          minus_seen_next;
  logic          needs_unit_next;
  status_t       err_next;

  logic          fire;
  logic [DW-1:0] dig_p;
  logic          dig_over;
  logic [PW-1:0] dig_h;
  logic [PW-1:0] dig_d;
  logic [PW-1:0] dig_w;
  logic [PW-1:0] mag_full;
  logic          mag_over;
  logic [W:0]    tot_ext;
  logic [W:0]    mag_ext;
  logic [W:0]    sum;
  logic          sum_ovf;
  status_t       end_status;

  // Result register frees up when it is empty or being taken
  assign q_ready = !results.valid || results.ready;
  assign fire    = q_valid && q_ready;

  // Digit: pending * 10 + d, and the same for each scaled copy
  always_comb begin
    dig_p    = ({4'b0, pend} << 3) + ({4'b0, pend} << 1) + DW'(q_item.digit);
    dig_over = |dig_p[DW-1:W-1];
    dig_h    = (pend_h << 3) + (pend_h << 1) + PW'(q_item.digit) * PW'(SCALE_H);
    dig_d    = (pend_d << 3) + (pend_d << 1) + PW'(q_item.digit) * PW'(SCALE_D);
    dig_w    = (pend_w << 3) + (pend_w << 1) + PW'(q_item.digit) * PW'(SCALE_W);
  end

  // Unit: pick the scaled term, range check, signed add with overflow
  always_comb begin
    case (q_item.unit)
      UNIT_MIN:  mag_full = PW'(pend);
      UNIT_HOUR: mag_full = pend_h;
      UNIT_DAY:  mag_full = pend_d;
      UNIT_WEEK: mag_full = pend_w;
      default:   mag_full = PW'(pend);
    endcase
    mag_over = |mag_full[PW-1:W-1];
    tot_ext  = {total[W-1], total};
    mag_ext  = {2'b00, mag_full[W-2:0]};
    sum      = minus_seen ? (tot_ext - mag_ext) : (tot_ext + mag_ext);
    sum_ovf  = sum[W] ^ sum[W-1];
  end

  // Status reported by an end item
  always_comb begin
    if (err != ST_OK) begin
      end_status = err;
    end else if (needs_unit) begin
      end_status = ST_NOUNIT;
    end else begin
      end_status = ST_OK;
    end
  end

  // Next state
  always_comb begin
    total_next      = total;
    pend_next       = pend;
    pend_h_next     = pend_h;
    pend_d_next     = pend_d;
    pend_w_next     = pend_w;
    minus_seen_next = minus_seen;
    needs_unit_next = needs_unit;
    err_next        = err;
    if (fire) begin
      if (q_item.cls == CLS_END) begin
        total_next      = '0;
        pend_next       = '0;
        pend_h_next     = '0;
        pend_d_next     = '0;
        pend_w_next     = '0;
        minus_seen_next = 1'b0;
        needs_unit_next = 1'b0;
        err_next        = ST_OK;
      end else if (err == ST_OK) begin
        case (q_item.cls)
          CLS_DIGIT: begin
            if (dig_over) begin
              err_next = ST_BOUNDS;
            end else begin
              pend_next       = dig_p[W-2:0];
              pend_h_next     = dig_h;
              pend_d_next     = dig_d;
              pend_w_next     = dig_w;
              needs_unit_next = 1'b1;
            end
          end
          CLS_MINUS: begin
            if (minus_seen) begin
              err_next = ST_INVALID;
            end else begin
              minus_seen_next = 1'b1;
              needs_unit_next = 1'b1;
            end
          end
          CLS_UNIT: begin
            if (mag_over || sum_ovf) begin
              err_next = ST_BOUNDS;
            end else begin
              total_next      = sum[W-1:0];
              pend_next       = '0;
              pend_h_next     = '0;
              pend_d_next     = '0;
              pend_w_next     = '0;
              minus_seen_next = 1'b0;
              needs_unit_next = 1'b0;
            end
          end
          default: err_next = ST_INVALID;
        endcase
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      total      <= '0;
      pend       <= '0;
      pend_h     <= '0;
      pend_d     <= '0;
      pend_w     <= '0;
      minus_seen <= 1'b0;
      needs_unit <= 1'b0;
      err        <= ST_OK;
    end else begin
      total      <= total_next;
      pend       <= pend_next;
      pend_h     <= pend_h_next;
      pend_d     <= pend_d_next;
      pend_w     <= pend_w_next;
      minus_seen <= minus_seen_next;
      needs_unit <= needs_unit_next;
      err        <= err_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (fire) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      if (q_item.cls == CLS_END) begin
        results.status        <= end_status;
        results.done_res      <= 1'b1;
        results.total_minutes <= total;
      end else begin
        results.status        <= err_next;
        results.done_res      <= 1'b0;
        results.total_minutes <= total_next;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // Scaled copies always track the pending value
  a_scaled_copies: assert property (@(posedge clk) disable iff (rst)
    pend_h == PW'(pend) * PW'(SCALE_H) && pend_d == PW'(pend) * PW'(SCALE_D) &&
    pend_w == PW'(pend) * PW'(SCALE_W))
    else $error("scaled pending copies out of step");

  // A pending minus always waits for a unit
  a_minus_needs_unit: assert property (@(posedge clk) disable iff (rst)
    minus_seen |-> needs_unit)
    else $error("minus flag set without unit pending");

  // End item leaves a clean state
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    fire && q_item.cls == CLS_END |=>
      total == '0 && pend == '0 && !minus_seen && !needs_unit && err == ST_OK)
    else $error("state not cleared after end of text");

  // Once in error, the total holds until the end item
  a_error_freezes_total: assert property (@(posedge clk) disable iff (rst)
    fire && err != ST_OK && q_item.cls != CLS_END |=> total == $past(total))
    else $error("total moved while an error is pending");
`endif

endmodule

`default_nettype wire

// ----- bench/tb_duration_text_parser.sv -----
// ----------------------------------------------------------------------------
// tb_duration_text_parser: self-checking bench for the duration text parser
// Feeds character streams (directed strings, then random well-formed,
// overflowing, broken and noise strings) through the input channel, predicts
// status and running total per transfer, and checks every result in order
// while both sides idle, stall and pause.
// ----------------------------------------------------------------------------

module tb_duration_text_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import dtp_pkg::*;

  localparam int TW = 64;
  localparam logic [TW-1:0] MAG_LIMIT = {1'b0, {(TW-1){1'b1}}};
  localparam int RANDOM_ITEMS = 1950;
  localparam int PAUSE_EVERY  = 450;
  localparam int HOLD_AT      = 1500;
  localparam int HOLD_CYCLES  = 300;

  typedef struct {
    logic [7:0] ch;
    logic       eot;
    bit         drain;
  } text_item_t;

  typedef struct {
    status_t               status;
    logic                  done;
    logic signed [TW-1:0]  total;
  } minute_result_t;

  logic clk;
  logic rst;

  dtp_in_if                      chars_if ();
  dtp_out_if #(.TOTAL_WIDTH(TW)) res_if ();

  duration_text_parser #(.TOTAL_WIDTH(TW)) i_dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if),
    .results (res_if)
  );

  text_item_t     text_fifo[$];
  minute_result_t due_results[$];
  minute_result_t want;
  bit             drain_pending;
  int             next_pause;
  int             taken_cnt;
  int             err_cnt;
  int             hold_left;
  bit             hold_done;

  // predictor state
  logic signed [TW-1:0] acc_total;
  logic [TW-1:0]        digit_acc;
  bit                   neg_flag;
  bit                   unit_due;
  status_t              sticky_err;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Safety net
  initial begin
    #5_000_000;
    $display("tb_duration_text_parser: errors");
    $finish;
  end

  // Expected result of one input transfer; updates the predictor state
  function automatic minute_result_t parse_char(input logic [7:0] ch, input logic eot);
    minute_result_t r;
    logic [TW-1:0]  d;
    logic [TW-1:0]  scale;
    logic [TW-1:0]  mag;
    bit             is_unit;
    r.done = eot;
    if (eot) begin
      r.status = (sticky_err == ST_OK && unit_due) ? ST_NOUNIT : sticky_err;
      r.total  = acc_total;
      acc_total  = '0;
      digit_acc  = '0;
      neg_flag   = 1'b0;
      unit_due   = 1'b0;
      sticky_err = ST_OK;
      return r;
    end
    if (sticky_err == ST_OK) begin
      is_unit = 1'b1;
      scale   = TW'(1);
      case (ch)
        CH_M: scale = TW'(1);
        CH_H: scale = TW'(SCALE_H);
        CH_D: scale = TW'(SCALE_D);
        CH_W: scale = TW'(SCALE_W);
        default: is_unit = 1'b0;
      endcase
      if (ch >= CH_0 && ch <= CH_9) begin
        d = TW'(ch - CH_0);
        if (digit_acc > (MAG_LIMIT - d) / 10) begin
          sticky_err = ST_BOUNDS;
        end else begin
          digit_acc = digit_acc * 10 + d;
          unit_due  = 1'b1;
        end
      end else if (ch == CH_MINUS) begin
        // a second minus before the unit is rejected
        if (neg_flag) begin
          sticky_err = ST_INVALID;
        end else begin
          neg_flag = 1'b1;
          unit_due = 1'b1;
        end
      end else if (is_unit) begin
        if (digit_acc > MAG_LIMIT / scale) begin
          sticky_err = ST_BOUNDS;
        end else begin
          mag = digit_acc * scale;
          if (!neg_flag && mag != 0 && acc_total > $signed(MAG_LIMIT) - $signed(mag)) begin
            sticky_err = ST_BOUNDS;
          end else if (neg_flag && mag != 0 &&
                       acc_total < $signed(~MAG_LIMIT) + $signed(mag)) begin
            sticky_err = ST_BOUNDS;
          end else begin
            acc_total = neg_flag ? acc_total - $signed(mag) : acc_total + $signed(mag);
            digit_acc = '0;
            neg_flag  = 1'b0;
            unit_due  = 1'b0;
          end
        end
      end else begin
        sticky_err = ST_INVALID;
      end
    end
    r.status = sticky_err;
    r.total  = acc_total;
    return r;
  endfunction

  // Idle rates by phase of the run
  function automatic int send_idle_pct();
    return (taken_cnt < 650) ? 10 : ((taken_cnt < 1300) ? 74 : 0);
  endfunction

  function automatic int recv_idle_pct();
    return (taken_cnt < 650) ? 74 : ((taken_cnt < 1300) ? 10 : 0);
  endfunction

  // Stimulus builders
  task automatic push_char(input logic [7:0] ch);
    text_fifo.push_back('{ch: ch, eot: 1'b0, drain: drain_pending});
    drain_pending = 1'b0;
  endtask

  task automatic push_end();
    text_fifo.push_back('{ch: 8'($urandom_range(255)), eot: 1'b1, drain: drain_pending});
    drain_pending = 1'b0;
  endtask

  task automatic push_text(input string s);
    foreach (s[i]) push_char(s[i]);
  endtask

  task automatic push_digits(input int n);
    for (int i = 0; i < n; i++) push_char(8'(CH_0 + $urandom_range(9)));
  endtask

  function automatic logic [7:0] pick_unit();
    case ($urandom_range(3))
      0: return CH_M;
      1: return CH_H;
      2: return CH_D;
      default: return CH_W;
    endcase
  endfunction

  // One term: optional sign, usually digits, then a unit letter
  task automatic push_term(input bit extreme);
    int n;
    if (extreme) begin
      if ($urandom_range(1)) push_char(CH_MINUS);
      case ($urandom_range(2))
        0: push_text("9223372036854775807");
        1: push_digits($urandom_range(20, 15));
        default: push_char(8'(CH_0 + 1));
      endcase
      push_char($urandom_range(1) ? CH_M : pick_unit());
    end else begin
      n = ($urandom_range(9) == 0) ? $urandom_range(14, 5) : $urandom_range(4, 1);
      case ($urandom_range(9))
        0, 1, 2: begin
          push_char(CH_MINUS);
          push_digits(n);
        end
        3: begin
          // digits on both sides of the minus form one number
          push_digits($urandom_range(2, 1));
          push_char(CH_MINUS);
          push_digits(n);
        end
        4: if ($urandom_range(1)) push_char(CH_MINUS);
        default: push_digits(n);
      endcase
      push_char(pick_unit());
    end
  endtask

  // One random string ending in an end marker
  task automatic push_random_string();
    int kind;
    kind = $urandom_range(99);
    if (kind < 55) begin
      repeat ($urandom_range(4, 1)) push_term(1'b0);
    end else if (kind < 70) begin
      repeat ($urandom_range(3, 1)) push_term(1'b1);
    end else if (kind < 85) begin
      repeat ($urandom_range(2)) push_term(1'b0);
      case ($urandom_range(3))
        0: push_digits($urandom_range(3, 1));
        1: push_char(CH_MINUS);
        2: begin
          push_char(CH_MINUS);
          push_digits(1);
          push_char(CH_MINUS);
          push_char(pick_unit());
        end
        default: begin
          push_char(8'($urandom_range(255)));
          push_term(1'b0);
        end
      endcase
    end else begin
      repeat ($urandom_range(6, 1)) push_char(8'($urandom_range(255)));
    end
    push_end();
  endtask

  // Driver: presents queued characters, records expectations per transfer
  always @(posedge clk) begin
    if (rst) begin
      chars_if.valid <= 1'b0;
    end else begin
      if (chars_if.valid && chars_if.ready) begin
        due_results.push_back(parse_char(chars_if.char_byte, chars_if.end_of_text));
        taken_cnt <= taken_cnt + 1;
      end
      if (!chars_if.valid || chars_if.ready) begin
        if (text_fifo.size() != 0 && !(text_fifo[0].drain && due_results.size() != 0) &&
            $urandom_range(99) >= send_idle_pct()) begin
          chars_if.char_byte   <= text_fifo[0].ch;
          chars_if.end_of_text <= text_fifo[0].eot;
          chars_if.valid       <= 1'b1;
          void'(text_fifo.pop_front());
        end else begin
          chars_if.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, once, while the sender keeps going
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && taken_cnt >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Monitor: checks each result transfer against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (due_results.size() == 0) begin
          $error("result transfer with nothing expected: status %0d total %0d",
                 res_if.status, res_if.total_minutes);
          err_cnt++;
        end else begin
          want = due_results.pop_front();
          if (res_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, res_if.status);
            err_cnt++;
          end
          if (res_if.done_res !== want.done) begin
            $error("done_res: expected %0d, got %0d", want.done, res_if.done_res);
            err_cnt++;
          end
          if (res_if.total_minutes !== want.total) begin
            $error("total_minutes: expected %0d, got %0d", want.total, res_if.total_minutes);
            err_cnt++;
          end
        end
      end
      res_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct());
    end
  end

  // Reset, stimulus and end of run
  initial begin
    rst                  = 1'b1;
    chars_if.valid       = 1'b0;
    chars_if.char_byte   = '0;
    chars_if.end_of_text = 1'b0;
    res_if.ready         = 1'b0;
    acc_total            = '0;
    digit_acc            = '0;
    neg_flag             = 1'b0;
    unit_due             = 1'b0;
    sticky_err           = ST_OK;
    drain_pending        = 1'b0;

    // directed: empty string, mixed signs, joined digits, missing unit,
    // double minus, odd bytes
    push_end();
    push_text("1w-2d30m");
    push_end();
    push_text("1-2m");
    push_end();
    push_char(CH_MINUS);
    push_end();
    push_char(8'(CH_0 + 7));
    push_end();
    push_text("--");
    push_end();
    push_char(8'h00);
    push_end();
    push_char(8'hFF);
    push_end();

    // random strings, with a full drain now and then
    drain_pending = 1'b1;
    next_pause    = text_fifo.size() + PAUSE_EVERY;
    while (text_fifo.size() < RANDOM_ITEMS) begin
      if (text_fifo.size() >= next_pause) begin
        drain_pending = 1'b1;
        next_pause += PAUSE_EVERY;
      end
      push_random_string();
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (text_fifo.size() != 0 || chars_if.valid || due_results.size() != 0);
    repeat (20) @(posedge clk);

    if (err_cnt == 0 && due_results.size() == 0) begin
      $display("tb_duration_text_parser: clean");
    end else begin
      $display("tb_duration_text_parser: errors");
    end
    $finish;
  end

endmodule
